>>> hdl/m2mp_pkg.sv
// shared types and constants of the 2x2 modular matrix power block
`default_nettype none
package m2mp_pkg;

    localparam int EXP_BITS_DEFAULT = 31;
    localparam int DIV_STEPS = 33;

    typedef struct packed {
        logic [31:0]        entry_a;
        logic [31:0]        entry_b;
        logic [31:0]        entry_c;
        logic [31:0]        entry_d;
        logic signed [31:0] exponent;
        logic [31:0]        modulus;
    } m2mp_in_t;

    typedef struct packed {
        logic [63:0] result_a;
        logic [63:0] result_b;
        logic [63:0] result_c;
        logic [63:0] result_d;
    } m2mp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIT,
        ST_SQCHK,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_ENTRY,
        ST_COMMIT,
        ST_OUT
    } m2mp_state_t;

endpackage
`default_nettype wire

>>> hdl/m2mp_mul.sv
// registered 32x32 multiplier shared by all matrix products
`default_nettype none
module m2mp_mul (
    input  wire logic        aclk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic [63:0]      prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> hdl/m2mp_mod.sv
// iterative remainder unit, two dividend bits per cycle
`default_nettype none
module m2mp_mod
    import m2mp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [64:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      rem
);

    localparam logic [5:0] CNT_LAST = 6'(DIV_STEPS - 1);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [65:0] num_reg;
    logic [31:0] rem_reg;
    logic [31:0] r1;
    logic [31:0] r2;

    function automatic logic [31:0] rstep(logic [31:0] r, logic b, logic [31:0] m);
        logic [32:0] t;
        t = {r, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[31:0];
    endfunction

    always_comb begin
        r1 = rstep(rem_reg, num_reg[65], divisor);
        r2 = rstep(r1, num_reg[64], divisor);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {1'b0, dividend};
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[63:0], 2'b00};
            rem_reg <= r2;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

>>> hdl/matrix2x2_modular_power_top.sv
// top level: 2x2 matrix power by square-and-multiply, optionally modulo m
//
// input items arrive on s_valid/s_ready/s_item, results leave on
// m_valid/m_ready/m_item, one result per item
// s_ready is high only while the sequencer is idle; one item at a time
// each matrix product takes four entries; an entry costs six passes
// through the shared 32x32 multiplier and, with a nonzero modulus, one
// run of the remainder unit at two bits per cycle; an exponent with top
// set bit n takes up to 2n+1 products, and a zero or negative exponent
// takes none
// the result sits in an output register; a new item is taken while it
// waits, and a finished result waits in the sequencer if it is still held
// reset (aresetn low, synchronous) empties the output and idles the block
`default_nettype none
module matrix2x2_modular_power_top
    import m2mp_pkg::*;
#(
    parameter int EXPONENT_BITS = EXP_BITS_DEFAULT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire m2mp_in_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output m2mp_out_t      m_item
);

    localparam logic [32:0] EFULL = (33'd1 << EXPONENT_BITS) - 33'd1;
    localparam logic [31:0] EMASK = EFULL[31:0];
    localparam logic [2:0]  MSTEP_LAST = 3'd5;

    m2mp_state_t state_reg, state_next;

    logic [31:0] e_reg;
    logic [31:0] mod_reg;
    logic        use_sq_reg;
    logic [1:0]  ent_reg;
    logic [2:0]  mstep_reg;
    logic [64:0] sum_reg;
    logic [64:0] sum_next;
    logic [63:0] acc0_reg, acc1_reg, acc2_reg, acc3_reg;
    logic [63:0] sq0_reg, sq1_reg, sq2_reg, sq3_reg;
    logic [63:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic        m_valid_reg;
    m2mp_out_t   m_item_reg;

    logic [63:0] p0, p1, p2, p3;
    logic [63:0] xa, ya, xb, yb, x, y;
    logic [31:0] op_a, op_b;
    logic        shift_hi;
    logic [63:0] prod;
    logic [64:0] addend;
    logic        mod_start;
    logic        mod_done;
    logic [31:0] mod_rem;
    logic        out_free;
    logic        last_step;

    m2mp_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    m2mp_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (sum_next),
        .divisor  (mod_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // operand selection for the current entry and partial product
    always_comb begin
        p0 = use_sq_reg ? sq0_reg : acc0_reg;
        p1 = use_sq_reg ? sq1_reg : acc1_reg;
        p2 = use_sq_reg ? sq2_reg : acc2_reg;
        p3 = use_sq_reg ? sq3_reg : acc3_reg;
        case (ent_reg)
            2'd0: begin xa = p0; ya = sq0_reg; xb = p1; yb = sq2_reg; end
            2'd1: begin xa = p0; ya = sq1_reg; xb = p1; yb = sq3_reg; end
            2'd2: begin xa = p2; ya = sq0_reg; xb = p3; yb = sq2_reg; end
            default: begin xa = p2; ya = sq1_reg; xb = p3; yb = sq3_reg; end
        endcase
        x = (mstep_reg >= 3'd3) ? xb : xa;
        y = (mstep_reg >= 3'd3) ? yb : ya;
        case (mstep_reg)
            3'd0, 3'd3: begin op_a = x[31:0];  op_b = y[31:0];  shift_hi = 1'b0; end
            3'd1, 3'd4: begin op_a = x[31:0];  op_b = y[63:32]; shift_hi = 1'b1; end
            default:    begin op_a = x[63:32]; op_b = y[31:0];  shift_hi = 1'b1; end
        endcase
    end

    always_comb begin
        addend   = shift_hi ? {1'b0, prod[31:0], 32'd0} : {1'b0, prod};
        sum_next = ((mstep_reg == 3'd0) ? 65'd0 : sum_reg) + addend;
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (mstep_reg == MSTEP_LAST);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_BIT;
            ST_BIT:    state_next = e_reg[0] ? ST_MUL : ST_SQCHK;
            ST_SQCHK:  state_next = (e_reg[31:1] == 31'd0) ? ST_OUT : ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC: begin
                if (!last_step) state_next = ST_MUL;
                else if (mod_reg != 32'd0) state_next = ST_DIV;
                else state_next = ST_ENTRY;
            end
            ST_DIV:    if (mod_done) state_next = ST_ENTRY;
            ST_ENTRY:  state_next = (ent_reg == 2'd3) ? ST_COMMIT : ST_MUL;
            ST_COMMIT: state_next = use_sq_reg ? ST_BIT : ST_SQCHK;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        mod_start = (state_reg == ST_ACC) && last_step && (mod_reg != 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    e_reg    <= s_item.exponent[31] ? 32'd0 : (s_item.exponent & EMASK);
                    mod_reg  <= s_item.modulus;
                    acc0_reg <= 64'd1;
                    acc1_reg <= 64'd0;
                    acc2_reg <= 64'd0;
                    acc3_reg <= 64'd1;
                    sq0_reg  <= {32'd0, s_item.entry_a};
                    sq1_reg  <= {32'd0, s_item.entry_b};
                    sq2_reg  <= {32'd0, s_item.entry_c};
                    sq3_reg  <= {32'd0, s_item.entry_d};
                end
            end
            ST_BIT: begin
                use_sq_reg <= 1'b0;
                ent_reg    <= 2'd0;
                mstep_reg  <= 3'd0;
            end
            ST_SQCHK: begin
                use_sq_reg <= 1'b1;
                ent_reg    <= 2'd0;
                mstep_reg  <= 3'd0;
            end
            ST_ACC: begin
                sum_reg   <= sum_next;
                mstep_reg <= mstep_reg + 3'd1;
                if (last_step && mod_reg == 32'd0) begin
                    case (ent_reg)
                        2'd0:    t0_reg <= sum_next[63:0];
                        2'd1:    t1_reg <= sum_next[63:0];
                        2'd2:    t2_reg <= sum_next[63:0];
                        default: t3_reg <= sum_next[63:0];
                    endcase
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    case (ent_reg)
                        2'd0:    t0_reg <= {32'd0, mod_rem};
                        2'd1:    t1_reg <= {32'd0, mod_rem};
                        2'd2:    t2_reg <= {32'd0, mod_rem};
                        default: t3_reg <= {32'd0, mod_rem};
                    endcase
                end
            end
            ST_ENTRY: begin
                ent_reg   <= ent_reg + 2'd1;
                mstep_reg <= 3'd0;
            end
            ST_COMMIT: begin
                if (use_sq_reg) begin
                    sq0_reg <= t0_reg;
                    sq1_reg <= t1_reg;
                    sq2_reg <= t2_reg;
                    sq3_reg <= t3_reg;
                    e_reg   <= {1'b0, e_reg[31:1]};
                end else begin
                    acc0_reg <= t0_reg;
                    acc1_reg <= t1_reg;
                    acc2_reg <= t2_reg;
                    acc3_reg <= t3_reg;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_item_reg.result_a <= acc0_reg;
                    m_item_reg.result_b <= acc1_reg;
                    m_item_reg.result_c <= acc2_reg;
                    m_item_reg.result_d <= acc3_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

>>> hdl/m2mp_checker.sv
// port-level checks of the matrix power block, bound to the top level
`default_nettype none
module m2mp_checker
    import m2mp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire m2mp_out_t m_item
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready again straight after an accepted item");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result changed");

endmodule

bind matrix2x2_modular_power_top m2mp_checker u_m2mp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire
